@@ rtl/lifestep_pkg.sv @@
// Shared types and constants for the life generation step unit.
// Used by the top level and the row rule evaluator; depends on nothing.
package lifestep_pkg;

  // Request opcodes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } opcode_e;

  // Neighbor count width: up to 8 live neighbors.
  localparam int unsigned NBR_W = 4;

  // B3/S23 rule thresholds.
  localparam logic [NBR_W-1:0] SURVIVE_CNT = 4'd2;
  localparam logic [NBR_W-1:0] BIRTH_CNT   = 4'd3;

  // Population result width and its saturation limit.
  localparam int unsigned POP_OUT_W = 13;
  localparam logic [POP_OUT_W-1:0] POP_MAX = 13'h1FFF;

  // Bits per population count chunk.
  localparam int unsigned CHUNK_W = 8;

endpackage

@@ rtl/lifestep_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependencies.
module lifestep_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/lifestep_rule_row.sv @@
// Next-generation rule for one full grid row, one lane per column.
// Depends on lifestep_pkg for the B3/S23 thresholds.
module lifestep_rule_row
  import lifestep_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic [GRID_SIZE-1:0] above_i,
  input  logic [GRID_SIZE-1:0] mid_i,
  input  logic [GRID_SIZE-1:0] below_i,
  output logic [GRID_SIZE-1:0] next_o
);

  // Rows padded with a dead cell at each edge, so there is no wraparound.
  logic [GRID_SIZE+1:0] above_pad;
  logic [GRID_SIZE+1:0] mid_pad;
  logic [GRID_SIZE+1:0] below_pad;
  logic [NBR_W-1:0]     nbr_cnt;

  assign above_pad = {1'b0, above_i, 1'b0};
  assign mid_pad   = {1'b0, mid_i, 1'b0};
  assign below_pad = {1'b0, below_i, 1'b0};

  // Count the eight neighbors of each column and apply the rule.
  always_comb begin
    next_o  = '0;
    nbr_cnt = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      nbr_cnt = NBR_W'(above_pad[c]) + NBR_W'(above_pad[c+1]) + NBR_W'(above_pad[c+2])
              + NBR_W'(mid_pad[c])                             + NBR_W'(mid_pad[c+2])
              + NBR_W'(below_pad[c]) + NBR_W'(below_pad[c+1]) + NBR_W'(below_pad[c+2]);
      next_o[c] = (nbr_cnt == BIRTH_CNT) || (mid_pad[c+1] && (nbr_cnt == SURVIVE_CNT));
    end
  end

endmodule

@@ rtl/life_automaton_generation_step_unit.sv @@
// Top level of the life generation step unit: request handling, grid memory
// and generation sequencer. Depends on lifestep_pkg, lifestep_ram and
// lifestep_rule_row.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o) writes
// one cell, reads one cell, or advances the whole grid one generation under
// the B3/S23 rule. Every request gives exactly one response on the output
// channel (out_valid_o / out_stall_i): the read cell value, or the new live
// population after a step (saturated at 8191), zeros otherwise.
// The grid sits in a RAM of GRID_SIZE rows, one row per word. A cell write is
// a read-modify-write of its row. A step streams every row once through a
// three-row window, computing one new row per cycle and writing it back; the
// rows are read ahead through the one RAM read port. One request is in work
// at a time; a new request is taken as soon as the sequencer is idle, even
// while a response still waits. Reset clears a valid bit per row, so every
// cell reads dead; no clearing pass is needed. If the receiver stalls, the
// response holds in the output register and the sequencer waits before
// loading the next one.
module life_automaton_generation_step_unit
  import lifestep_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [5:0]           row_i,
  input  logic [5:0]           col_i,
  input  logic                 cell_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cell_out_o,
  output logic [POP_OUT_W-1:0] population_o
);

  localparam int unsigned AW     = $clog2(GRID_SIZE);
  localparam int unsigned CW     = AW + 7;
  localparam int unsigned PW     = $clog2(GRID_SIZE * GRID_SIZE + 1);
  localparam int unsigned NCH    = (GRID_SIZE + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned CCW    = $clog2(CHUNK_W + 1);
  localparam int unsigned SW     = $clog2(NCH * CHUNK_W + 1);
  localparam int unsigned SATW   = PW + POP_OUT_W;
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_MERGE,
    ST_RD_DATA,
    ST_STEP_LOAD,
    ST_STEP_ROW,
    ST_STEP_DRAIN,
    ST_RESULT
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          row_q;
  logic [AW-1:0]          col_q;
  logic                   bit_q;
  logic [AW-1:0]          rcnt_q;
  logic [GRID_SIZE-1:0]   row_valid_q;
  logic                   rd_valid_q;
  logic                   new_valid_q;
  logic                   sum_valid_q;
  logic [PW-1:0]          pop_q;
  logic                   res_cell_q;
  logic [POP_OUT_W-1:0]   res_pop_q;
  logic                   out_valid_q;
  logic                   cell_out_q;
  logic [POP_OUT_W-1:0]   population_q;

  logic [GRID_SIZE-1:0]   win_above_q;
  logic [GRID_SIZE-1:0]   win_mid_q;
  logic [GRID_SIZE-1:0]   row_new_q;
  logic [CCW-1:0]         chunk_q [NCH];

  logic                   accept;
  logic                   in_grid;
  logic                   out_free;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [GRID_SIZE-1:0]   ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [GRID_SIZE-1:0]   ram_rdata;
  logic [GRID_SIZE-1:0]   rdata_m;
  logic [GRID_SIZE-1:0]   merged_row;
  logic [GRID_SIZE-1:0]   below_row;
  logic [GRID_SIZE-1:0]   next_row;
  logic [AW:0]            rcnt_plus2;
  logic                   prefetch;
  logic [NCH*CHUNK_W-1:0] new_pad;
  logic [CCW-1:0]         chunk_d [NCH];
  logic [SW-1:0]          chunk_sum;
  logic [POP_OUT_W-1:0]   pop_sat;

  // Handshake.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;
  assign population_o = population_q;

  // Address check against the grid size.
  assign in_grid = (CW'(row_i) < CW'(GRID_SIZE)) && (CW'(col_i) < CW'(GRID_SIZE));

  // Rows never written since reset read as dead.
  assign rdata_m = rd_valid_q ? ram_rdata : '0;

  // Row with the addressed cell replaced.
  always_comb begin
    merged_row        = rdata_m;
    merged_row[col_q] = bit_q;
  end

  // Row below the one being computed; past the last row it is dead.
  assign below_row  = (rcnt_q == LAST_ROW) ? '0 : rdata_m;
  assign rcnt_plus2 = (AW + 1)'(rcnt_q) + (AW + 1)'(2);
  assign prefetch   = rcnt_plus2 < (AW + 1)'(GRID_SIZE);

  lifestep_rule_row #(
    .GRID_SIZE(GRID_SIZE)
  ) u_rule_row (
    .above_i(win_above_q),
    .mid_i  (win_mid_q),
    .below_i(below_row),
    .next_o (next_row)
  );

  // Memory port selection.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = merged_row;
    case (state_q)
      ST_IDLE: begin
        ram_re    = accept && in_grid;
        ram_raddr = AW'(row_i);
        if (accept && (opcode_e'(opcode_i) == OP_STEP)) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      ST_WR_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = row_q;
      end
      ST_STEP_LOAD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
      end
      ST_STEP_ROW: begin
        ram_re    = prefetch;
        ram_raddr = AW'(rcnt_plus2);
        ram_we    = 1'b1;
        ram_waddr = rcnt_q;
        ram_wdata = next_row;
      end
      default: begin
      end
    endcase
  end

  lifestep_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Per-chunk population counts of the latest new row.
  assign new_pad = (NCH * CHUNK_W)'(row_new_q);
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      chunk_d[k] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        chunk_d[k] = chunk_d[k] + CCW'(new_pad[k*CHUNK_W+b]);
      end
    end
  end

  // Sum of the registered chunk counts.
  always_comb begin
    chunk_sum = '0;
    for (int k = 0; k < NCH; k++) begin
      chunk_sum = chunk_sum + SW'(chunk_q[k]);
    end
  end

  // Saturated population.
  assign pop_sat = (SATW'(pop_q) > SATW'(POP_MAX)) ? POP_MAX : POP_OUT_W'(pop_q);

  // Window and population datapath.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEP_LOAD) begin
      win_above_q <= '0;
      win_mid_q   <= rdata_m;
    end else if (state_q == ST_STEP_ROW) begin
      win_above_q <= win_mid_q;
      win_mid_q   <= below_row;
      row_new_q   <= next_row;
    end
    for (int k = 0; k < NCH; k++) begin
      chunk_q[k] <= chunk_d[k];
    end
  end

  // Sequencer, row valid bits and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      bit_q        <= 1'b0;
      rcnt_q       <= '0;
      row_valid_q  <= '0;
      rd_valid_q   <= 1'b0;
      new_valid_q  <= 1'b0;
      sum_valid_q  <= 1'b0;
      pop_q        <= '0;
      res_cell_q   <= 1'b0;
      res_pop_q    <= '0;
      out_valid_q  <= 1'b0;
      cell_out_q   <= 1'b0;
      population_q <= '0;
    end else begin
      if (ram_re) begin
        rd_valid_q <= row_valid_q[ram_raddr];
      end
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end

      // Population pipeline: count chunks, then accumulate.
      new_valid_q <= (state_q == ST_STEP_ROW);
      sum_valid_q <= new_valid_q;
      if (sum_valid_q) begin
        pop_q <= pop_q + PW'(chunk_sum);
      end

      // Output register.
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q  <= 1'b1;
        cell_out_q   <= res_cell_q;
        population_q <= res_pop_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            row_q      <= AW'(row_i);
            col_q      <= AW'(col_i);
            bit_q      <= cell_in_i;
            res_cell_q <= 1'b0;
            res_pop_q  <= '0;
            case (opcode_e'(opcode_i))
              OP_WRITE: state_q <= in_grid ? ST_WR_MERGE : ST_RESULT;
              OP_READ:  state_q <= in_grid ? ST_RD_DATA : ST_RESULT;
              OP_STEP: begin
                pop_q   <= '0;
                rcnt_q  <= '0;
                state_q <= ST_STEP_LOAD;
              end
              default:  state_q <= ST_RESULT;
            endcase
          end
        end
        ST_WR_MERGE: begin
          state_q <= ST_RESULT;
        end
        ST_RD_DATA: begin
          res_cell_q <= rdata_m[col_q];
          state_q    <= ST_RESULT;
        end
        ST_STEP_LOAD: begin
          state_q <= ST_STEP_ROW;
        end
        ST_STEP_ROW: begin
          rcnt_q <= rcnt_q + AW'(1);
          if (rcnt_q == LAST_ROW) begin
            state_q <= ST_STEP_DRAIN;
          end
        end
        ST_STEP_DRAIN: begin
          if (!new_valid_q && !sum_valid_q) begin
            res_pop_q <= pop_sat;
            state_q   <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
